[rtl/triangle_heightmap_interpolator_macros.svh]
// assertion macros for the triangle heightmap interpolator checker
// no dependencies; taken in by `include where assertions are written
`ifndef TRIANGLE_HEIGHTMAP_INTERPOLATOR_MACROS_SVH
`define TRIANGLE_HEIGHTMAP_INTERPOLATOR_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define THI_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("thi: same-cycle check failed");

// consequence holds in the cycle after the antecedent
`define THI_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("thi: next-cycle check failed");

`endif

[rtl/thi_pkg.sv]
// shared types and constants of the triangle heightmap interpolator
// no dependencies; used by every rtl module by scoped names
`timescale 1ns / 1ps

package thi_pkg;

   // grid and field sizes
   localparam int GRID_SIDE_DEFAULT = 64;
   localparam int COORD_W  = 6;
   localparam int HEIGHT_W = 16;
   localparam int POS_W    = 16;
   localparam int SCALED_W = POS_W + COORD_W;
   localparam int WEIGHT_W = POS_W + 1;
   localparam int ACC_W    = 34;

   // request word layout, lowest bit first
   localparam int REQ_DATA_W = 64;
   localparam int VX_LSB = 0;
   localparam int VY_LSB = VX_LSB + COORD_W;
   localparam int VH_LSB = VY_LSB + COORD_W;
   localparam int PX_LSB = VH_LSB + HEIGHT_W;
   localparam int PY_LSB = PX_LSB + POS_W;

   localparam int RSP_DATA_W = 16;

   localparam logic [COORD_W-1:0] QPS_RESET = 6'd63;

   // request kinds carried on req_tuser
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctl_type;

endpackage

[rtl/triangle_heightmap_interpolator.sv]
// top level of the triangle heightmap interpolator
// depends on thi_pkg, thi_height_mem and thi_mac
`timescale 1ns / 1ps

// usage
// - req channel: one word per item; req_tuser says load (0) or query (1)
// - a load writes one vertex height into the grid store in the cycle it is
//   accepted and gives no rsp word; loads outside the grid are dropped
// - a query gives one rsp word: the truncated height and, on rsp_tuser,
//   whether the point fell in the south-west/south-east/north-west triangle
// - loads are taken back to back, one a cycle, while no query is worked on
// - a query is taken, then the three corner heights are read one per cycle
//   through the single read port of the store and fed to one multiplier;
//   the sum then moves to the output register, and the req side opens
//   again in the same cycle as the rsp word turns valid
// - the rsp word sits in an output register; while the receiver stalls,
//   loads and a further query are still taken, and that query holds its sum
//   until the output register is free
// - csr_wr_en writes quads_per_side; zero counts as one and counts beyond
//   the grid are clipped to the grid; write it only while idle
// - reset clears the handshake state and sets quads_per_side to 63; the
//   height store is not cleared, so every vertex must be loaded before use

module triangle_heightmap_interpolator #(
   parameter int GRID_SIDE = thi_pkg::GRID_SIDE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: vertex_x[5:0], vertex_y[11:6], vertex_height[27:12],
   //            pos_x[43:28], pos_y[59:44], zero pad[63:60]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [thi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: req_type[0]
   input  logic                            req_tuser,
   // rsp_tdata: interp_height[15:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [thi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: lower_triangle[0]
   output logic                            rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [thi_pkg::COORD_W-1:0]     csr_wr_data
);

   localparam int CW   = $clog2(GRID_SIDE);
   localparam int AW   = 2 * CW;
   localparam int QMAX = (GRID_SIDE - 1 > 63) ? 63 : GRID_SIDE - 1;
   localparam int CNT_LAST = 4;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;

   logic [thi_pkg::COORD_W-1:0] q_ff, q_in, q_eff;

   logic [thi_pkg::SCALED_W-1:0] sx_ff, sy_ff, sx_in, sy_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [thi_pkg::HEIGHT_W-1:0] rsp_height_ff;
   logic                                rsp_lower_ff;

   // request fields
   logic [thi_pkg::COORD_W-1:0]         vertex_x, vertex_y;
   logic signed [thi_pkg::HEIGHT_W-1:0] vertex_height;
   logic [thi_pkg::POS_W-1:0]           pos_x, pos_y;

   assign vertex_x      = req_tdata[thi_pkg::VX_LSB +: thi_pkg::COORD_W];
   assign vertex_y      = req_tdata[thi_pkg::VY_LSB +: thi_pkg::COORD_W];
   assign vertex_height = req_tdata[thi_pkg::VH_LSB +: thi_pkg::HEIGHT_W];
   assign pos_x         = req_tdata[thi_pkg::PX_LSB +: thi_pkg::POS_W];
   assign pos_y         = req_tdata[thi_pkg::PY_LSB +: thi_pkg::POS_W];

   logic accept, accept_query, load_wr;
   logic out_free, out_load;

   assign req_tready   = (state_ff == S_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign accept_query = accept && (req_tuser == thi_pkg::REQ_QUERY);
   assign load_wr      = accept && (req_tuser == thi_pkg::REQ_LOAD) &&
                         (32'(vertex_x) < GRID_SIDE) && (32'(vertex_y) < GRID_SIDE);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == S_DONE) && out_free;

   // quad count register, clipped into the usable range
   assign q_in = csr_wr_en ? csr_wr_data : q_ff;

   always_comb begin
      q_eff = q_ff;
      if (q_ff == '0) begin
         q_eff = thi_pkg::COORD_W'(1);
      end else if (32'(q_ff) > QMAX) begin
         q_eff = thi_pkg::COORD_W'(QMAX);
      end
   end

   // scale the point by the quad count: cell index above, fraction below
   assign sx_in = {{thi_pkg::COORD_W{1'b0}}, pos_x} *
                  {{thi_pkg::POS_W{1'b0}}, q_eff};
   assign sy_in = {{thi_pkg::COORD_W{1'b0}}, pos_y} *
                  {{thi_pkg::POS_W{1'b0}}, q_eff};

   always_ff @(posedge clock) begin
      if (accept_query) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
   end

   // cell, fractions and triangle choice
   logic [thi_pkg::COORD_W-1:0] cx, cy, cx1, cy1;
   logic [thi_pkg::POS_W-1:0]   u, v;
   logic [thi_pkg::POS_W:0]     uv_sum;
   logic                        lower;

   assign cx  = sx_ff[thi_pkg::SCALED_W-1:thi_pkg::POS_W];
   assign cy  = sy_ff[thi_pkg::SCALED_W-1:thi_pkg::POS_W];
   // cell index stays below the clipped quad count, so +1 never wraps
   assign cx1 = cx + thi_pkg::COORD_W'(1);
   assign cy1 = cy + thi_pkg::COORD_W'(1);
   assign u   = sx_ff[thi_pkg::POS_W-1:0];
   assign v   = sy_ff[thi_pkg::POS_W-1:0];
   assign uv_sum = {1'b0, u} + {1'b0, v};
   assign lower  = !uv_sum[thi_pkg::POS_W];

   // corner read order: lower uses sw, se, nw; upper uses ne, nw, se
   logic [thi_pkg::COORD_W-1:0] rd_col, rd_row;
   logic [AW-1:0]               rd_addr, wr_addr;

   always_comb begin
      rd_col = cx;
      rd_row = cy;
      case (cnt_ff[1:0])
         2'd0: begin
            rd_col = lower ? cx : cx1;
            rd_row = lower ? cy : cy1;
         end
         2'd1: begin
            rd_col = lower ? cx1 : cx;
            rd_row = lower ? cy  : cy1;
         end
         2'd2: begin
            rd_col = lower ? cx  : cx1;
            rd_row = lower ? cy1 : cy;
         end
         default: begin
            rd_col = cx;
            rd_row = cy;
         end
      endcase
   end

   assign rd_addr = {CW'(rd_row), CW'(rd_col)};
   assign wr_addr = {CW'(vertex_y), CW'(vertex_x)};

   // weight for the corner whose height arrives this cycle
   logic [1:0]                  w_idx;
   logic [thi_pkg::WEIGHT_W-1:0] weight;
   logic [thi_pkg::WEIGHT_W-1:0] one_q16;

   assign one_q16 = {1'b1, {thi_pkg::POS_W{1'b0}}};
   assign w_idx   = 2'(cnt_ff - 3'd1);

   always_comb begin
      case (w_idx)
         2'd0:    weight = lower ? (one_q16 - uv_sum) : (uv_sum - one_q16);
         2'd1:    weight = lower ? {1'b0, u} : (one_q16 - {1'b0, u});
         2'd2:    weight = lower ? {1'b0, v} : (one_q16 - {1'b0, v});
         default: weight = '0;
      endcase
   end

   logic signed [thi_pkg::HEIGHT_W-1:0] rd_data;
   logic signed [thi_pkg::HEIGHT_W-1:0] mac_result;
   thi_pkg::mac_ctl_type                mac_ctl;

   thi_height_mem #(
      .AW(AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (wr_addr),
      .wr_data (vertex_height),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read at steps 0..2, multiply at 1..3, accumulate at 2..4
   always_comb begin
      mac_ctl.clear  = accept_query;
      mac_ctl.mul_en = (state_ff == S_CALC) && (cnt_ff >= 3'd1) && (cnt_ff <= 3'd3);
      mac_ctl.acc_en = (state_ff == S_CALC) && (cnt_ff >= 3'd2) &&
                       (cnt_ff <= 3'(CNT_LAST));
   end

   thi_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .height (rd_data),
      .weight (weight),
      .result (mac_result)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept_query) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(CNT_LAST)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         q_ff         <= thi_pkg::QPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_height_ff <= mac_result;
         rsp_lower_ff  <= lower;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_height_ff;
   assign rsp_tuser  = rsp_lower_ff;

endmodule

[rtl/thi_height_mem.sv]
// vertex height store: one write port, one registered read port
// depends on thi_pkg for the height width
`timescale 1ns / 1ps

module thi_height_mem #(
   parameter int AW = 12
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [thi_pkg::HEIGHT_W-1:0]  wr_data,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [thi_pkg::HEIGHT_W-1:0]  rd_data
);

   localparam int DEPTH = 1 << AW;

   logic signed [thi_pkg::HEIGHT_W-1:0] mem [DEPTH];
   logic signed [thi_pkg::HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/thi_mac.sv]
// weighted sum of three corner heights and truncation toward zero
// depends on thi_pkg for widths and the control struct
`timescale 1ns / 1ps

module thi_mac (
   input  logic                                 clock,
   input  thi_pkg::mac_ctl_type                 ctl,
   input  logic signed [thi_pkg::HEIGHT_W-1:0]  height,
   input  logic [thi_pkg::WEIGHT_W-1:0]         weight,
   output logic signed [thi_pkg::HEIGHT_W-1:0]  result
);

   localparam int AW = thi_pkg::ACC_W;

   logic signed [AW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] shifted;
   logic                 round_up;

   // weight is unsigned, so give it a zero sign bit before the signed multiply
   assign prod_in = AW'(height) * AW'($signed({1'b0, weight}));

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // divide by one in q16 with truncation toward zero
   assign shifted  = acc_ff >>> thi_pkg::POS_W;
   assign round_up = acc_ff[AW-1] && (acc_ff[thi_pkg::POS_W-1:0] != '0);
   assign result   = thi_pkg::HEIGHT_W'(shifted + AW'(round_up));

endmodule

[rtl/thi_checker.sv]
// port-level checks on the triangle heightmap interpolator, bound to the top
// depends on thi_pkg, triangle_heightmap_interpolator_macros.svh and the top level
`timescale 1ns / 1ps
`include "triangle_heightmap_interpolator_macros.svh"

module thi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [thi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser
);

   // a stalled rsp word holds
   `THI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset leaves the block ready with nothing to send
   `THI_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_tready && !rsp_tvalid)

   // a query closes the req side while it is worked on
   `THI_ASSERT_NEXT(a_query_busy, clock, reset, req_tvalid && req_tready && (req_tuser == thi_pkg::REQ_QUERY), !req_tready)

   // a load never produces a word of its own
   `THI_ASSERT_NEXT(a_load_silent, clock, reset, req_tvalid && req_tready && (req_tuser == thi_pkg::REQ_LOAD) && !rsp_tvalid, !rsp_tvalid)

   // a new rsp word only appears at the end of a query, with the req side closed
   `THI_ASSERT_SAME(a_rsp_from_query, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind triangle_heightmap_interpolator thi_checker u_thi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
